FILE: rtl/core/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX
  } mode_e;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSL   = 8'h5C;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_N     = 8'h6E;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_U     = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_MASK6 = 8'h3F;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;

  typedef struct packed {
    logic [1:0]      count;
    logic            str_end;
    logic [2:0][7:0] bytes;
  } dec_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/jsu_decode.sv
module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  logic [7:0]    byte_i,
  output jsu_pkg::dec_t dec_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     digits_q, digits_d;
  logic [15:0]    cp_q, cp_d;
  logic [15:0]    cp_next;

  assign cp_next = {cp_q[11:0], jsu_pkg::hex_value(byte_i)};

  always_comb begin
    mode_d        = mode_q;
    digits_d      = digits_q;
    cp_d          = cp_q;
    dec_o.count   = 2'd0;
    dec_o.str_end = 1'b0;
    dec_o.bytes   = '0;
    unique case (mode_q)
      jsu_pkg::MODE_ESC: begin
        mode_d         = jsu_pkg::MODE_PLAIN;
        dec_o.count    = 2'd1;
        dec_o.bytes[0] = byte_i;
        unique case (byte_i)
          jsu_pkg::CHR_NUL: begin
            dec_o.str_end = 1'b1;
            digits_d      = 2'd0;
            cp_d          = '0;
          end
          jsu_pkg::CHR_B: dec_o.bytes[0] = jsu_pkg::CTL_BS;
          jsu_pkg::CHR_F: dec_o.bytes[0] = jsu_pkg::CTL_FF;
          jsu_pkg::CHR_N: dec_o.bytes[0] = jsu_pkg::CTL_LF;
          jsu_pkg::CHR_R: dec_o.bytes[0] = jsu_pkg::CTL_CR;
          jsu_pkg::CHR_T: dec_o.bytes[0] = jsu_pkg::CTL_HT;
          jsu_pkg::CHR_U: begin
            mode_d      = jsu_pkg::MODE_HEX;
            digits_d    = 2'd0;
            cp_d        = '0;
            dec_o.count = 2'd0;
          end
          default: ;
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (byte_i == jsu_pkg::CHR_NUL) begin
          mode_d        = jsu_pkg::MODE_PLAIN;
          digits_d      = 2'd0;
          cp_d          = '0;
          dec_o.count   = 2'd1;
          dec_o.str_end = 1'b1;
        end else if (digits_q == 2'd3) begin
          mode_d   = jsu_pkg::MODE_PLAIN;
          digits_d = 2'd0;
          cp_d     = '0;
          if (cp_next < jsu_pkg::UTF8_ONE_LIMIT) begin
            dec_o.count    = 2'd1;
            dec_o.bytes[0] = cp_next[7:0];
          end else if (cp_next < jsu_pkg::UTF8_TWO_LIMIT) begin
            dec_o.count    = 2'd2;
            dec_o.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_next[10:6]};
            dec_o.bytes[1] = jsu_pkg::UTF8_CONT | (cp_next[7:0] & jsu_pkg::UTF8_MASK6);
          end else begin
            dec_o.count    = 2'd3;
            dec_o.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'h0, cp_next[15:12]};
            dec_o.bytes[1] = jsu_pkg::UTF8_CONT | (cp_next[13:6] & jsu_pkg::UTF8_MASK6);
            dec_o.bytes[2] = jsu_pkg::UTF8_CONT | (cp_next[7:0] & jsu_pkg::UTF8_MASK6);
          end
        end else begin
          cp_d     = cp_next;
          digits_d = digits_q + 2'd1;
        end
      end
      default: begin
        mode_d = jsu_pkg::MODE_PLAIN;
        if (byte_i == jsu_pkg::CHR_NUL || byte_i == jsu_pkg::CHR_QUOTE) begin
          digits_d      = 2'd0;
          cp_d          = '0;
          dec_o.count   = 2'd1;
          dec_o.str_end = 1'b1;
        end else if (byte_i == jsu_pkg::CHR_BSL) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          dec_o.count    = 2'd1;
          dec_o.bytes[0] = byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= jsu_pkg::MODE_PLAIN;
      digits_q <= 2'd0;
      cp_q     <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      cp_q     <= cp_d;
    end
  end

endmodule

FILE: rtl/core/jsu_obuf.sv
module jsu_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  jsu_pkg::dec_t dec_i,
  input  logic          out_stall_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          string_end_o,
  output logic          last_of_run_o
);

  logic [1:0]      cnt_q, cnt_d;
  logic            end_q, end_d;
  logic [2:0][7:0] slot_q, slot_d;
  logic            xfer;

  assign xfer          = (cnt_q != 2'd0) && !out_stall_i;
  assign ready_o       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign out_valid_o   = cnt_q != 2'd0;
  assign out_byte_o    = slot_q[0];
  assign string_end_o  = end_q;
  assign last_of_run_o = cnt_q == 2'd1;

  always_comb begin
    cnt_d  = cnt_q;
    end_d  = end_q;
    slot_d = slot_q;
    if (load_i && dec_i.count != 2'd0) begin
      cnt_d  = dec_i.count;
      end_d  = dec_i.str_end;
      slot_d = dec_i.bytes;
    end else if (xfer) begin
      cnt_d  = cnt_q - 2'd1;
      slot_d = {8'h00, slot_q[2], slot_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      end_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

FILE: rtl/core/json_string_unescaper_unit.sv
// Stages: input register, combinational decode, result register presenting each result.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields
// two or three UTF-8 bytes holds the input while the result register drains.
// Bytes yielding no result (backslash, u, first three hex digits) only update decode state.
// Reset: asynchronous, active low; clears valid flags and returns to plain mode.
module json_string_unescaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       string_end_o,
  output logic       last_of_run_o
);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          buf_ready;
  logic          advance;
  jsu_pkg::dec_t dec;

  assign advance    = in_valid_q && buf_ready;
  assign in_stall_o = in_valid_q && !buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .dec_o     (dec)
  );

  jsu_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .dec_i         (dec),
    .out_stall_i   (out_stall_i),
    .ready_o       (buf_ready),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .string_end_o  (string_end_o),
    .last_of_run_o (last_of_run_o)
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> last_of_run_o)
    else $error("end marker not last of run");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> out_byte_o == 8'h00)
    else $error("end marker carries nonzero byte");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |=> out_valid_o)
    else $error("run dropped before its last byte");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] ch;
  logic       fin;
  logic       last;
} char_t;

class unescape_scoreboard;
  jsu_pkg::mode_e mode;
  logic [1:0]     digits;
  logic [15:0]    cp;
  char_t          expected_chars[$];
  int             mismatches;

  function new();
    mode = jsu_pkg::MODE_PLAIN;
    digits = 2'd0;
    cp = 16'h0000;
    mismatches = 0;
  endfunction

  function logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] d;
    d = 4'h0;
    if (c >= "0" && c <= "9") begin
      d = c[3:0];
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

  function void add(input logic [7:0] ch, input logic fin);
    char_t e;
    e.ch = ch;
    e.fin = fin;
    e.last = 1'b0;
    expected_chars.push_back(e);
  endfunction

  function void finish_string();
    add(8'h00, 1'b1);
    mode = jsu_pkg::MODE_PLAIN;
    digits = 2'd0;
    cp = 16'h0000;
  endfunction

  function void encode_utf8(input logic [15:0] v);
    if (v < jsu_pkg::UTF8_ONE_LIMIT) begin
      add(v[7:0], 1'b0);
    end else if (v < jsu_pkg::UTF8_TWO_LIMIT) begin
      add(jsu_pkg::UTF8_LEAD2 | {3'b000, v[10:6]}, 1'b0);
      add(jsu_pkg::UTF8_CONT | (v[7:0] & jsu_pkg::UTF8_MASK6), 1'b0);
    end else begin
      add(jsu_pkg::UTF8_LEAD3 | {4'h0, v[15:12]}, 1'b0);
      add(jsu_pkg::UTF8_CONT | ({2'b00, v[11:6]} & jsu_pkg::UTF8_MASK6), 1'b0);
      add(jsu_pkg::UTF8_CONT | (v[7:0] & jsu_pkg::UTF8_MASK6), 1'b0);
    end
  endfunction

  function void note_byte(input logic [7:0] c);
    int          start_sz;
    logic [15:0] v;
    start_sz = expected_chars.size();
    case (mode)
      jsu_pkg::MODE_ESC: begin
        mode = jsu_pkg::MODE_PLAIN;
        case (c)
          jsu_pkg::CHR_NUL: finish_string();
          jsu_pkg::CHR_B:   add(jsu_pkg::CTL_BS, 1'b0);
          jsu_pkg::CHR_F:   add(jsu_pkg::CTL_FF, 1'b0);
          jsu_pkg::CHR_N:   add(jsu_pkg::CTL_LF, 1'b0);
          jsu_pkg::CHR_R:   add(jsu_pkg::CTL_CR, 1'b0);
          jsu_pkg::CHR_T:   add(jsu_pkg::CTL_HT, 1'b0);
          jsu_pkg::CHR_U: begin
            mode = jsu_pkg::MODE_HEX;
            digits = 2'd0;
            cp = 16'h0000;
          end
          default: add(c, 1'b0);
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (c == jsu_pkg::CHR_NUL) begin
          finish_string();
        end else begin
          v = {cp[11:0], nibble_of(c)};
          cp = v;
          if (digits == 2'd3) begin
            encode_utf8(v);
            mode = jsu_pkg::MODE_PLAIN;
            digits = 2'd0;
            cp = 16'h0000;
          end else begin
            digits = digits + 2'd1;
          end
        end
      end
      default: begin
        mode = jsu_pkg::MODE_PLAIN;
        if (c == jsu_pkg::CHR_NUL || c == jsu_pkg::CHR_QUOTE) begin
          finish_string();
        end else if (c == jsu_pkg::CHR_BSL) begin
          mode = jsu_pkg::MODE_ESC;
        end else begin
          add(c, 1'b0);
        end
      end
    endcase
    if (expected_chars.size() > start_sz) begin
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    end
  endfunction

  function void check_result(input logic [7:0] ch, input logic fin, input logic last);
    char_t e;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected transfer: byte %02h end %0b last %0b", ch, fin, last);
      end
    end else begin
      e = expected_chars.pop_front();
      if (e.ch !== ch || e.fin !== fin || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                   e.ch, e.fin, e.last, ch, fin, last);
        end
      end
    end
  endfunction
endclass

module tb_top;

  localparam int         RANDOM_BYTES = 450;
  localparam int         QUIET_LIMIT  = 2000;
  localparam logic [7:0] CHR_SLASH    = 8'h2F;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       string_end_o;
  logic       last_of_run_o;

  unescape_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  json_string_unescaper_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .string_end_o (string_end_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(in_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_byte_o, string_end_o, last_of_run_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_escape(input logic [7:0] c);
    send_byte(jsu_pkg::CHR_BSL);
    send_byte(c);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else if ($urandom_range(1) == 0) begin
      c = 8'h57 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

  task automatic send_unicode();
    logic [15:0] cp;
    int          k;
    case ($urandom_range(2))
      0:       cp = 16'($urandom_range(16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    send_escape(jsu_pkg::CHR_U);
    for (int i = 3; i >= 0; i--) begin
      k = $urandom_range(99);
      if (k < 4) begin
        send_byte(jsu_pkg::CHR_NUL);
        return;
      end else if (k < 8) begin
        send_byte(jsu_pkg::CHR_QUOTE);
      end else if (k < 14) begin
        send_byte(8'($urandom_range(8'h67, 8'hFF)));
      end else begin
        send_byte(hex_char(cp[4*i +: 4]));
      end
    end
  endtask

  task automatic send_random_escape();
    logic [7:0] pick[8];
    pick = '{jsu_pkg::CHR_B, jsu_pkg::CHR_F, jsu_pkg::CHR_N, jsu_pkg::CHR_R, jsu_pkg::CHR_T,
             jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSL, CHR_SLASH};
    case ($urandom_range(9))
      0:       send_escape(8'($urandom_range(255)));
      1:       send_escape($urandom_range(4) == 0 ? jsu_pkg::CHR_NUL
                                                  : 8'($urandom_range(1, 255)));
      default: send_escape(pick[$urandom_range(7)]);
    endcase
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_byte(8'hFF);
    send_escape(jsu_pkg::CHR_B);
    send_escape(jsu_pkg::CHR_F);
    send_escape(jsu_pkg::CHR_N);
    send_escape(jsu_pkg::CHR_R);
    send_escape(jsu_pkg::CHR_T);
    send_escape(jsu_pkg::CHR_QUOTE);
    send_escape(jsu_pkg::CHR_U);
    repeat (4) send_byte("F");
    send_escape(jsu_pkg::CHR_U);
    repeat (4) send_byte(jsu_pkg::CHR_QUOTE);
    send_escape(jsu_pkg::CHR_NUL);
    send_escape(jsu_pkg::CHR_U);
    send_byte("A");
    send_byte(jsu_pkg::CHR_NUL);
    send_byte(jsu_pkg::CHR_QUOTE);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      gaps_on = !(bytes_sent >= 150 && bytes_sent < 270);
      k = $urandom_range(99);
      if (k < 40) begin
        send_byte($urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E))
                                    : 8'($urandom_range(1, 255)));
      end else if (k < 60) begin
        send_random_escape();
      end else if (k < 85) begin
        send_unicode();
      end else if (k < 93) begin
        send_byte($urandom_range(3) == 0 ? jsu_pkg::CHR_NUL : jsu_pkg::CHR_QUOTE);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    gaps_on = 1'b1;
    in_valid_i <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
